FILE: src/lzss_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// LZSS stream decoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECODER_MACROS_SVH
`define LZSS_STREAM_DECODER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LZSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define LZSD_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

FILE: src/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS stream decoder package
// Shared constants, controller state type and controller/datapath links.
// ----------------------------------------------------------------------------
package lzsd_pkg;

   localparam int LZSD_RING_DEPTH      = 4096;
   localparam int LZSD_MAX_MATCH       = 18;
   localparam int LZSD_MATCH_THRESHOLD = 2;

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   // Commands from the controller; at most one is high in a cycle.
   typedef struct packed {
      logic lit_wr;      // literal byte: emit and write to the ring
      logic pair_lo;     // first pair byte: hold the low position bits
      logic pair_start;  // second pair byte: load source and count
      logic copy_step;   // emit and write back one copied byte
   } cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic out_valid;   // output register holds an untaken byte
      logic copy_last;   // the current copy byte is the final one
   } status_type;

endpackage

FILE: src/lzsd_ctrl.sv
// ----------------------------------------------------------------------------
// LZSS stream decoder controller
// Flag tracking, pair sequencing and the copy state machine.
// ----------------------------------------------------------------------------
module lzsd_ctrl
   import lzsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_ready,
   input  status_type st,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type   state_ff, state_in;
   logic [7:0]  flag_bits_ff, flag_bits_in;
   logic [3:0]  flags_left_ff, flags_left_in;
   logic        pending_ff, pending_in;
   logic        slot_free;
   logic        accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         pending_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         pending_ff    <= pending_in;
      end
   end

   always_comb begin
      slot_free     = !st.out_valid || rsp_ready;
      state_in      = state_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      pending_in    = pending_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      accept        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = slot_free;
            accept    = req_valid && slot_free;
            if (accept) begin
               if (flags_left_ff == 4'd0) begin
                  flag_bits_in  = req_in_byte;
                  flags_left_in = 4'd8;
               end else if (flag_bits_ff[0]) begin
                  cmd.lit_wr    = 1'b1;
                  flag_bits_in  = {1'b0, flag_bits_ff[7:1]};
                  flags_left_in = flags_left_ff - 4'd1;
               end else if (!pending_ff) begin
                  cmd.pair_lo = 1'b1;
                  pending_in  = 1'b1;
               end else begin
                  cmd.pair_start = 1'b1;
                  pending_in     = 1'b0;
                  flag_bits_in   = {1'b0, flag_bits_ff[7:1]};
                  flags_left_in  = flags_left_ff - 4'd1;
                  state_in       = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            cmd.copy_step = slot_free;
            if (slot_free && st.copy_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/lzsd_datapath.sv
// ----------------------------------------------------------------------------
// LZSS stream decoder datapath
// History ring, write pointer, copy source pointer and output register.
// ----------------------------------------------------------------------------
module lzsd_datapath
   import lzsd_pkg::*;
#(
   parameter int RING_DEPTH      = LZSD_RING_DEPTH,
   parameter int MAX_MATCH       = LZSD_MAX_MATCH,
   parameter int MATCH_THRESHOLD = LZSD_MATCH_THRESHOLD
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] in_byte,
   input  logic       rsp_ready,
   output status_type st,
   output logic       out_valid,
   output logic [7:0] out_byte,
   output logic       out_last
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam int CW = $clog2(MAX_MATCH + 1);
   localparam logic [AW-1:0] WP_RESET  = AW'(RING_DEPTH - MAX_MATCH);
   localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);

   logic [7:0]    ring [RING_DEPTH];
   logic [7:0]    mem_q_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] rd_addr_ff, rd_addr;
   logic          rd_ok_ff, rd_ok_in;
   logic          byp_ff, byp_in;
   logic [7:0]    byp_data_ff;
   logic [7:0]    pos_low_ff;
   logic [CW-1:0] count_ff, count_in, count_raw;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic [7:0]    copy_data;
   logic [7:0]    wr_data;
   logic          we;
   logic [AW-1:0] rd_dist;

   always_comb begin
      copy_data = byp_ff ? byp_data_ff : (rd_ok_ff ? mem_q_ff : 8'd0);
      wr_data   = cmd.lit_wr ? in_byte : copy_data;
      we        = cmd.lit_wr || cmd.copy_step;
      if (cmd.pair_start) begin
         rd_addr = AW'({in_byte[7:4], pos_low_ff});
      end else begin
         rd_addr = rd_addr_ff + AW'(cmd.copy_step);
      end
      // Written entries form one run starting at the reset write position.
      rd_dist  = rd_addr - WP_RESET;
      rd_ok_in = FW'(rd_dist) < fill_ff;
      byp_in   = we && (rd_addr == wp_ff);
      wp_in    = we ? wp_ff + AW'(1) : wp_ff;
      fill_in  = (we && fill_ff != FILL_FULL) ? fill_ff + FW'(1) : fill_ff;
      count_raw = CW'(in_byte[3:0]) + CW'(MATCH_THRESHOLD + 1);
      if (cmd.pair_start) begin
         count_in = (count_raw > CW'(MAX_MATCH)) ? CW'(MAX_MATCH) : count_raw;
      end else if (cmd.copy_step) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
      if (we) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         ring[wp_ff] <= wr_data;
      end
      mem_q_ff <= ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= WP_RESET;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr;
      rd_ok_ff    <= rd_ok_in;
      byp_ff      <= byp_in;
      byp_data_ff <= wr_data;
      count_ff    <= count_in;
      if (cmd.pair_lo) begin
         pos_low_ff <= in_byte;
      end
      if (we) begin
         out_byte_ff <= wr_data;
         out_last_ff <= cmd.lit_wr || (count_ff == CW'(1));
      end
   end

   assign st.out_valid = out_valid_ff;
   assign st.copy_last = (count_ff == CW'(1));
   assign out_valid    = out_valid_ff;
   assign out_byte     = out_byte_ff;
   assign out_last     = out_last_ff;

endmodule

FILE: src/lzss_stream_decoder.sv
// ----------------------------------------------------------------------------
// LZSS stream decoder
// Streaming LZSS decompressor with a 4096-byte history ring.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per request transaction and returns
// the decompressed bytes as response transactions, with rsp_run_last marking
// the final byte caused by one request. A flag byte and a first pair byte
// are only stored, a literal is written to the ring and the output register;
// the second byte of a pair is accepted and then streams its L+3 copied
// bytes, at most 18, at one per cycle while the consumer keeps taking them.
// That rate is set by the single read port of the history ring, which
// yields one copied byte per cycle. Requests are held off while a copy runs
// and while the output register holds a byte that the consumer has not
// taken. There is no clearing pass after reset: a fill count tracks the run
// of ring entries written since reset, and reads outside it return zero.
// ----------------------------------------------------------------------------
`include "lzss_stream_decoder_macros.svh"

module lzss_stream_decoder
   import lzsd_pkg::*;
#(
   parameter int RING_DEPTH      = LZSD_RING_DEPTH,
   parameter int MAX_MATCH       = LZSD_MAX_MATCH,
   parameter int MATCH_THRESHOLD = LZSD_MATCH_THRESHOLD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   cmd_type    cmd;
   status_type st;
   logic       emit;

   // The controller decodes flags and sequences pairs and copies.
   lzsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .rsp_ready   (rsp_ready),
      .st          (st),
      .req_ready   (req_ready),
      .cmd         (cmd)
   );

   // The datapath owns the ring, the pointers and the output register.
   lzsd_datapath #(
      .RING_DEPTH      (RING_DEPTH),
      .MAX_MATCH       (MAX_MATCH),
      .MATCH_THRESHOLD (MATCH_THRESHOLD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_byte   (req_in_byte),
      .rsp_ready (rsp_ready),
      .st        (st),
      .out_valid (rsp_valid),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_run_last)
   );

   // A literal or a copy step puts one byte into the output register.
   assign emit = cmd.lit_wr || cmd.copy_step;

   // Only one datapath command may be issued in a cycle.
   `LZSD_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command")

   // Once a copy starts, no request is taken in the following cycle.
   `LZSD_ASSERT_NEXT(a_copy_busy, clock, reset, cmd.pair_start, !req_ready, "request during copy")

   // Every emitted byte lands in the output register.
   `LZSD_ASSERT_NEXT(a_emit_valid, clock, reset, emit, rsp_valid, "emitted byte not presented")

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// LZSS stream decoder testbench
// Streams compressed bytes into the decoder and checks every decompressed
// byte against a transaction-level model of the decompressor.
// ----------------------------------------------------------------------------
// The stimulus starts with a short hand-written stream that covers literal
// extremes, the shortest and longest copies, a copy that overlaps the write
// position, a copy whose source wraps around the end of the ring and a copy
// from a part of the ring that has never been written. It then generates
// random but mostly well-formed streams: a shadow copy of the model tracks
// where the stream stands, so flag bytes, literals and pairs arrive in the
// order the decoder expects them, with most copies aimed at recent output.
// A small share of the bytes is plain noise. The stream ends with a pair
// whose second byte never comes, which must produce nothing.
// ----------------------------------------------------------------------------
module tb
   import lzsd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // What the decoder will take the next compressed byte to be.
   typedef enum logic [1:0] {
      NEXT_FLAG,
      NEXT_LITERAL,
      NEXT_POS_LOW,
      NEXT_POS_HIGH
   } stream_slot_type;

   // One decompressed byte as it should appear on the response channel.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   // The model of the decompressor. It keeps its own history ring and parser
   // state, turns each accepted request byte into the response bytes that it
   // must cause, and checks the responses in order.
   class lzss_expect_board;
      logic [7:0]   ring [LZSD_RING_DEPTH];
      logic [11:0]  wr_pos;
      logic [7:0]   flag_bits;
      logic [3:0]   flags_left;
      bit           pair_open;
      logic [7:0]   pos_low;
      out_beat_type pending_q [$];
      int           errors;
      int           n_checked;
      int           n_requests;
      int           n_flags;
      int           n_literals;
      int           n_copies;
      int           n_copy_bytes;
      int           n_overlap;

      function new();
         foreach (ring[i]) ring[i] = 8'h00;
         wr_pos     = 12'(LZSD_RING_DEPTH - LZSD_MAX_MATCH);
         flag_bits  = 8'h00;
         flags_left = 4'd0;
         pair_open  = 1'b0;
         pos_low    = 8'h00;
      endfunction

      function stream_slot_type next_kind();
         if (flags_left == 4'd0) return NEXT_FLAG;
         if (flag_bits[0]) return NEXT_LITERAL;
         if (!pair_open) return NEXT_POS_LOW;
         return NEXT_POS_HIGH;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      function void put_byte(logic [7:0] b, logic last);
         ring[wr_pos] = b;
         wr_pos       = wr_pos + 12'd1;
         pending_q.push_back('{data: b, last: last});
      endfunction

      function void next_flag();
         flag_bits  = flag_bits >> 1;
         flags_left = flags_left - 4'd1;
      endfunction

      function void note_request(logic [7:0] b);
         logic [11:0] src;
         logic [11:0] back_gap;
         int          count;
         n_requests++;
         case (next_kind())
            NEXT_FLAG: begin
               flag_bits  = b;
               flags_left = 4'd8;
               n_flags++;
            end
            NEXT_LITERAL: begin
               put_byte(b, 1'b1);
               next_flag();
               n_literals++;
            end
            NEXT_POS_LOW: begin
               pos_low   = b;
               pair_open = 1'b1;
            end
            default: begin
               src      = {b[7:4], pos_low};
               count    = b[3:0] + LZSD_MATCH_THRESHOLD + 1;
               back_gap = wr_pos - src;
               if (back_gap != 12'd0 && back_gap < count) n_overlap++;
               // Byte by byte, so an overlapping copy reads what it just wrote.
               for (int k = 0; k < count; k++) begin
                  put_byte(ring[src + k[11:0]], k == count - 1);
               end
               pair_open = 1'b0;
               next_flag();
               n_copies++;
               n_copy_bytes += count;
            end
         endcase
      endfunction

      function void check_response(logic [7:0] got_byte, logic got_last);
         out_beat_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: response with no byte expected: out_byte %02h run_last %0b",
                     $time, got_byte, got_last);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         n_checked++;
         if (got_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, got_byte);
            errors++;
         end
         if (got_last !== want.last) begin
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, want.last, got_last);
            errors++;
         end
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   // The board checks the decoder; the shadow only follows the generated
   // stream so that the generator knows which kind of byte comes next.
   lzss_expect_board board  = new();
   lzss_expect_board shadow = new();

   int          n_sent    = 0;
   bit          calm      = 1'b0;   // no idling on either side
   bit          hold_long = 1'b0;   // asks the receiver for one long hold-off
   logic [11:0] copy_src  = 12'd0;
   logic [3:0]  copy_len  = 4'd0;

   lzss_stream_decoder DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Both channels are sampled at the rising edge, before this edge's
   // nonblocking updates land. A request transaction is modeled first, so a
   // response at the same edge always finds its expectation in place.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_in_byte);
         if (rsp_valid && rsp_ready) board.check_response(rsp_out_byte, rsp_run_last);
      end
   end

   // Receiver: short random stalls, plus one long hold-off on request. The
   // long one lasts well beyond anything the decoder can buffer, so its
   // request side has to stall while the sender keeps offering bytes.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one compressed byte and returns once it has been accepted. Valid
   // stays high into the next byte unless a random gap is taken.
   task automatic send_byte(input logic [7:0] b);
      shadow.note_request(b);
      shadow.pending_q.delete();
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      n_sent++;
   endtask

   // Stops offering bytes until every expected response has been taken.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Picks the next compressed byte from where the stream stands. Copies are
   // chosen when the low position byte is due; most of them point a short
   // distance back, some so close that source and destination overlap.
   function automatic logic [7:0] next_stream_byte(input bit allow_noise);
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (allow_noise && pick < 8) begin
         b = 8'($urandom_range(0, 255));
         return b;
      end
      case (shadow.next_kind())
         NEXT_FLAG: begin
            if (pick < 25) b = 8'h00;
            else if (pick < 40) b = 8'hFF;
            else b = 8'($urandom_range(0, 255));
         end
         NEXT_LITERAL: b = 8'($urandom_range(0, 255));
         NEXT_POS_LOW: begin
            pick = $urandom_range(0, 3);
            if (pick == 0) copy_len = 4'd0;
            else if (pick == 1) copy_len = 4'd15;
            else copy_len = 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 20) copy_src = shadow.wr_pos - 12'($urandom_range(1, 3));
            else if (pick < 65) copy_src = shadow.wr_pos - 12'($urandom_range(4, 64));
            else copy_src = 12'($urandom_range(0, LZSD_RING_DEPTH - 1));
            b = copy_src[7:0];
         end
         default: b = {copy_src[11:8], copy_len};
      endcase
      return b;
   endfunction

   // Hand-written opening stream. Eight literals with extreme and alternating
   // bit patterns land at 4078 onward. The next flag byte calls for four
   // pairs and four literals: a shortest copy of the first literals, a longest
   // copy from two bytes back that overlaps its own output and wraps the
   // write position past the end of the ring, a copy whose source wraps from
   // the last ring entry to the first, and a copy from a region that has
   // never been written and so reads zeros.
   logic [7:0] opening [22] = '{
      8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7E, 8'h81,
      8'hF0, 8'hEE, 8'hF0, 8'hF7, 8'hFF, 8'hFF, 8'hF1, 8'h23, 8'h17,
      8'h3C, 8'hC3, 8'h0F, 8'hF0
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_byte(opening[i]);
      drain_responses();

      // Random streams. Partway through, the receiver holds off for a long
      // stretch; later the sender waits for every response; the last part
      // runs with no idling at all.
      while (n_sent < 322) begin
         if (n_sent == 120) hold_long = 1'b1;
         if (n_sent == 200) drain_responses();
         if (n_sent == 262) calm = 1'b1;
         send_byte(next_stream_byte(1'b1));
      end

      // Finish the current flag group cleanly, then end on a flag byte and
      // the first byte of a pair that is never completed.
      while (shadow.next_kind() != NEXT_FLAG) send_byte(next_stream_byte(1'b0));
      send_byte(8'h00);
      send_byte(8'h5A);
      req_valid <= 1'b0;

      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      // Nothing more may come out; any stray response is caught here.
      repeat (40) @(posedge clock);

      $display("Streamed %0d compressed bytes: %0d flag bytes, %0d literals, %0d copies",
               board.n_requests, board.n_flags, board.n_literals, board.n_copies);
      $display("Copies produced %0d bytes (%0d overlapping copies); %0d bytes checked.",
               board.n_copy_bytes, board.n_overlap, board.n_checked);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // The slowest correct run is far below this, even with the longest copies,
   // every receiver stall and every sender gap.
   initial begin
      #5_000_000;
      $display("Timeout with %0d responses still expected.", board.pending());
      $display("Some tests failed");
      $finish;
   end

endmodule
